// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
package lkvc_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned KEY_W = 64;
    localparam int unsigned VAL_W = 64;
    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_data;

    typedef struct packed {
        logic cmp;
        logic upd_hit;
        logic upd_ins;
    } t_ctl;

endpackage

// ===== rtl/lkvc_cell.sv =====
`timescale 1ns / 1ps
module lkvc_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned FW  = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lkvc_pkg::t_ctl            i_ctl,
    input  logic [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic [FW-1:0]             i_lim,
    input  lkvc_pkg::t_data           i_prev,
    output lkvc_pkg::t_data           o_data,
    input  logic                      i_seen,
    output logic                      o_seen,
    input  logic [lkvc_pkg::VAL_W-1:0] i_acc,
    output logic [lkvc_pkg::VAL_W-1:0] o_acc
);

    logic                       r_valid;
    logic [lkvc_pkg::KEY_W-1:0] r_key;
    logic [lkvc_pkg::VAL_W-1:0] r_value;
    logic                       r_hit;
    logic                       w_load;

    always_comb begin
        if (i_ctl.upd_hit) begin
            w_load = !i_seen;
        end else begin
            w_load = i_ctl.upd_ins && (FW'(IDX) < i_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_hit <= r_valid && (r_key == i_key);
            end
            if (w_load) begin
                r_valid <= i_prev.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_data.valid = r_valid;
    assign o_data.key   = r_key;
    assign o_data.value = r_value;
    assign o_seen       = i_seen | r_hit;
    assign o_acc        = i_acc | (r_hit ? r_value : '0);

endmodule

// ===== rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement, kept as a
// row of cells ordered by recency (cell 0 most recent). A transaction is taken when
// start is high and busy is low; busy then stays high while the row compares the key
// in every cell (ST_CMP) and then, on a hit or a SET, shifts toward the back up to the
// hit or insertion point (ST_UPD). The result appears on o_result with o_done high for
// exactly one cycle, in the first cycle in which busy is low again; the receiver
// cannot stall it and must take it then. Capacity is written through the APB port at
// address 0 and should only change while busy is low.
module lru_key_value_cache #(
    parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lkvc_pkg::t_req        i_req,
    output logic                  o_done,
    output lkvc_pkg::t_rsp        o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned FW = $clog2(ENTRIES + 1);
    localparam int unsigned CW = (FW > lkvc_pkg::CAP_W) ? FW : lkvc_pkg::CAP_W;

    lkvc_pkg::t_state            r_state;
    lkvc_pkg::t_state            n_state;
    lkvc_pkg::t_req              r_req;
    lkvc_pkg::t_rsp              r_rsp;
    lkvc_pkg::t_rsp              n_rsp;
    logic                        r_done;
    logic [lkvc_pkg::CAP_W-1:0]  r_capacity;
    logic [FW-1:0]               r_fill;
    logic [FW-1:0]               n_fill;
    logic [CW-1:0]               w_cap_eff;
    logic                        w_evict;
    logic [FW-1:0]               w_lim;
    logic                        w_found;
    lkvc_pkg::t_ctl              w_ctl;
    logic                        w_accept;

    lkvc_pkg::t_data             w_data [ENTRIES+1];
    logic                        w_seen [ENTRIES+1];
    logic [lkvc_pkg::VAL_W-1:0]  w_acc  [ENTRIES+1];

    assign w_accept = start && !busy;
    assign busy     = (r_state != lkvc_pkg::ST_IDLE);
    assign w_found  = w_seen[ENTRIES];

    always_comb begin
        w_cap_eff = CW'(r_capacity);
        if (w_cap_eff == '0) begin
            w_cap_eff = CW'(1);
        end else if (w_cap_eff > CW'(ENTRIES)) begin
            w_cap_eff = CW'(ENTRIES);
        end
    end

    assign w_evict = (CW'(r_fill) >= w_cap_eff);
    assign w_lim   = w_evict ? r_fill : r_fill + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lkvc_pkg::ST_CMP;
                end
            end
            lkvc_pkg::ST_CMP: n_state = lkvc_pkg::ST_UPD;
            lkvc_pkg::ST_UPD: n_state = lkvc_pkg::ST_IDLE;
            default:          n_state = lkvc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl   = '0;
        n_fill  = r_fill;
        n_rsp.found      = w_found;
        n_rsp.read_value = (r_req.opcode == lkvc_pkg::OP_GET && w_found) ?
                           w_acc[ENTRIES] : '0;
        unique case (r_state)
            lkvc_pkg::ST_CMP: w_ctl.cmp = 1'b1;
            lkvc_pkg::ST_UPD: begin
                w_ctl.upd_hit = w_found;
                w_ctl.upd_ins = !w_found && (r_req.opcode == lkvc_pkg::OP_SET);
                if (w_ctl.upd_ins && !w_evict) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lkvc_pkg::ST_IDLE;
            r_done     <= 1'b0;
            r_fill     <= '0;
            r_capacity <= lkvc_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == lkvc_pkg::ST_UPD);
            r_fill  <= n_fill;
            if (psel && penable && pwrite && pready && paddr[2] == lkvc_pkg::REG_CAPACITY) begin
                r_capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (r_state == lkvc_pkg::ST_UPD) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_rsp;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == lkvc_pkg::REG_CAPACITY) ?
                      {{(32 - lkvc_pkg::CAP_W){1'b0}}, r_capacity} : '0;

    assign w_data[0].valid = 1'b1;
    assign w_data[0].key   = r_req.key;
    assign w_data[0].value = (r_req.opcode == lkvc_pkg::OP_SET) ? r_req.value : w_acc[ENTRIES];
    assign w_seen[0]       = 1'b0;
    assign w_acc[0]        = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkvc_cell #(
            .IDX (g),
            .FW  (FW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_key   (r_req.key),
            .i_lim   (w_lim),
            .i_prev  (w_data[g]),
            .o_data  (w_data[g+1]),
            .i_seen  (w_seen[g]),
            .o_seen  (w_seen[g+1]),
            .i_acc   (w_acc[g]),
            .o_acc   (w_acc[g+1])
        );
    end

endmodule

// ===== bench/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps
module lru_key_value_cache_tb;

    localparam int unsigned SLOTS = lkvc_pkg::ENTRIES_DEF;
    localparam logic [2:0] CAP_ADDR = 3'(4 * lkvc_pkg::REG_CAPACITY);
    localparam logic [2:0] STRAY_ADDR = 3'd4;
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASES = 6;
    localparam int unsigned PHASE_ITEMS = 72;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CAP,
        ROW_STRAY
    } t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic           op;
        logic [63:0]    key;
        logic [63:0]    data;
        logic           typed;
        lkvc_pkg::t_rsp want;
    } t_script_row;

    localparam int unsigned N_ROWS = 29;

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    lkvc_pkg::t_req i_req = '0;
    logic           o_done;
    lkvc_pkg::t_rsp o_result;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    logic [63:0]                  line_key [SLOTS];
    logic [63:0]                  line_val [SLOTS];
    bit                           line_live [SLOTS];
    int unsigned                  line_age [SLOTS];
    int unsigned                  live_count = 0;
    logic [lkvc_pkg::CAP_W-1:0]   capacity_reg = lkvc_pkg::CAP_RESET;

    lkvc_pkg::t_rsp pending_rsp [$];
    logic [63:0]    key_pool [$];
    int unsigned    mismatches = 0;
    int unsigned    stall_cycles = 0;
    lkvc_pkg::t_rsp oldest;

    t_script_row script [N_ROWS] = '{
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'd0, 64'd0, 1'b1, '{1'b0, 64'd0}},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, ONES,  ONES,  1'b1, '{1'b0, 64'd0}},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'd0, ONES,  1'b1, '{1'b0, 64'd0}},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'd0, 64'd0, 1'b1, '{1'b1, ONES}},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, ONES,  64'd0, 1'b1, '{1'b0, 64'd0}},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, ONES,  64'd0, 1'b1, '{1'b1, 64'd0}},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'd0, 64'd5, 1'b1, '{1'b1, 64'd0}},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'd0, 64'd0, 1'b1, '{1'b1, 64'd5}},
        '{ROW_CAP,   lkvc_pkg::OP_GET, 64'd0, 64'd0, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'd3, 64'h8000_0000_0000_0001, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, ONES,  64'd0, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'd0, 64'd0, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'd3, 64'd0, 1'b0, '0},
        '{ROW_CAP,   lkvc_pkg::OP_GET, 64'd0, 64'd31, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'h10, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'h11, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'h12, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'd3, 64'd0, 1'b0, '0},
        '{ROW_CAP,   lkvc_pkg::OP_GET, 64'd0, 64'd2, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'h20, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'h10, 64'd0, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'd3, 64'd0, 1'b0, '0},
        '{ROW_STRAY, lkvc_pkg::OP_GET, 64'd0, 64'd1, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'h21, 64'h1111_2222_3333_4444, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'h20, 64'd0, 1'b0, '0},
        '{ROW_CAP,   lkvc_pkg::OP_GET, 64'd0, 64'd16, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_SET, 64'h7FFF_FFFF_FFFF_FFFF, ONES, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'h8000_0000_0000_0000, 64'd0, 1'b0, '0},
        '{ROW_ITEM,  lkvc_pkg::OP_GET, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, '0}
    };

    lru_key_value_cache DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            line_key[i] = '0;
            line_val[i] = '0;
            line_live[i] = 1'b0;
            line_age[i] = 0;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned usable_capacity();
        int unsigned c;
        c = capacity_reg;
        if (c == 0) c = 1;
        if (c > SLOTS) c = SLOTS;
        return c;
    endfunction

    function automatic void make_newest(int s);
        int unsigned a;
        a = line_age[s];
        for (int i = 0; i < SLOTS; i++)
            if (line_live[i] && i != s && line_age[i] < a) line_age[i]++;
        line_age[s] = 0;
    endfunction

    function automatic lkvc_pkg::t_rsp cache_lookup(lkvc_pkg::t_req req);
        lkvc_pkg::t_rsp rsp;
        int             hit;
        int             slot;
        int unsigned    oldest_age;
        hit = -1;
        slot = -1;
        oldest_age = 0;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && line_live[i] && line_key[i] == req.key) hit = i;
        rsp.found = (hit >= 0);
        rsp.read_value = '0;
        if (hit >= 0) begin
            if (req.opcode == lkvc_pkg::OP_GET) rsp.read_value = line_val[hit];
            else line_val[hit] = req.value;
            make_newest(hit);
        end else if (req.opcode == lkvc_pkg::OP_SET) begin
            if (live_count >= usable_capacity()) begin
                for (int i = 0; i < SLOTS; i++)
                    if (line_live[i] && (slot < 0 || line_age[i] > oldest_age)) begin
                        slot = i;
                        oldest_age = line_age[i];
                    end
                make_newest(slot);
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && !line_live[i]) slot = i;
                for (int i = 0; i < SLOTS; i++)
                    if (line_live[i]) line_age[i]++;
                line_live[slot] = 1'b1;
                line_age[slot] = 0;
                live_count++;
            end
            line_key[slot] = req.key;
            line_val[slot] = req.value;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected result", o_result.read_value, '0);
            end else begin
                oldest = pending_rsp.pop_front();
                if (o_result.found !== oldest.found)
                    report_mismatch("found", 64'(o_result.found), 64'(oldest.found));
                if (o_result.read_value !== oldest.read_value)
                    report_mismatch("read_value", o_result.read_value, oldest.read_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (i_rst_n);
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(lkvc_pkg::t_req req, bit typed, lkvc_pkg::t_rsp want);
        lkvc_pkg::t_rsp predicted;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        predicted = cache_lookup(req);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic maybe_idle(bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady) return;
        if (r < 3) begin
            start <= 1'b0;
            drain();
        end else if (r < 19) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_register(logic [2:0] addr, logic [4:0] cap);
        logic [31:0] word;
        word = {27'($urandom), cap};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == CAP_ADDR) capacity_reg = word[lkvc_pkg::CAP_W-1:0];
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= CAP_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[lkvc_pkg::CAP_W-1:0] !== capacity_reg)
            report_mismatch("capacity readback", 64'(prdata[lkvc_pkg::CAP_W-1:0]),
                            64'(capacity_reg));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        lkvc_pkg::t_req req;
        int unsigned    cap_plan [PHASES];
        cap_plan = '{16, 1, 31, 0, 0, 16};
        cap_plan[4] = $urandom_range(2, 15);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_ROWS; n++) begin
            case (script[n].kind)
                ROW_ITEM: begin
                    req.opcode = script[n].op;
                    req.key = script[n].key;
                    req.value = script[n].data;
                    send_item(req, script[n].typed, script[n].want);
                    maybe_idle(1'b0);
                end
                ROW_CAP, ROW_STRAY: begin
                    start <= 1'b0;
                    drain();
                    write_register(script[n].kind == ROW_CAP ? CAP_ADDR : STRAY_ADDR,
                                   script[n].data[4:0]);
                end
                default: ;
            endcase
        end

        for (int p = 0; p < PHASES; p++) begin
            start <= 1'b0;
            drain();
            write_register(CAP_ADDR, 5'(cap_plan[p]));
            key_pool.delete();
            repeat (usable_capacity() + $urandom_range(1, 4)) key_pool.push_back(pick_word());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                req.opcode = $urandom_range(0, 1) ? lkvc_pkg::OP_SET : lkvc_pkg::OP_GET;
                if ($urandom_range(0, 99) < 85)
                    req.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else
                    req.key = pick_word();
                req.value = pick_word();
                send_item(req, 1'b0, '0);
                maybe_idle(p == 2);
            end
        end
        start <= 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache.sv
bench/lru_key_value_cache_tb.sv
